// ----- rtl/rlebc_pkg.sv -----
// Shared types and constants for the byte run-length compressor.
// Holds the configuration register map, the emit and packer status structs
// and the default sizes. No dependencies.
package rlebc_pkg;

  // Default sizes
  localparam int DEF_MAX_BLOCK = 127;
  localparam int DEF_OUT_BYTES = 8;

  // Field widths on the ports
  localparam int DATA_W      = 8;
  localparam int PACKED_W    = 64;
  localparam int COUNT_W     = 4;
  localparam int OUT_TDATA_W = 72;
  localparam int LEN_W       = 32;
  localparam int REG_IDX_W   = 1;

  // Length header and repeat block marker
  localparam int          HDR_BYTES   = 4;
  localparam logic [7:0]  REPEAT_FLAG = 8'h80;

  // Configuration register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_EMBED_LENGTH    = 1'b0,
    REG_ORIGINAL_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             embed_length;
    logic [LEN_W-1:0] original_length;
  } cfg_t;

  // One compressed byte towards the packer, plus the end-of-item close request
  typedef struct packed {
    logic             vld;
    logic [DATA_W-1:0] value;
    logic             close;
    logic             eos;
  } emit_t;

  // Packer status back to the sequencer
  typedef struct packed {
    logic emit_stall;
    logic close_ok;
  } pk_stat_t;

endpackage

// ----- rtl/rlebc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the literal store. No dependencies.
module rlebc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry through the read data register
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rlebc_packer.sv -----
// Byte packer and output register: gathers compressed bytes into beats of up
// to OUT_BYTES bytes and closes the last beat of each item.
// Depends on rlebc_pkg.
module rlebc_packer #(
  parameter int OUT_BYTES = rlebc_pkg::DEF_OUT_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rlebc_pkg::emit_t                    emit,
  output rlebc_pkg::pk_stat_t                 stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rlebc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // packed_bytes, byte_count
  output logic                                out_tuser,  // last_of_input
  output logic                                out_tlast   // end_of_stream
);

  import rlebc_pkg::*;

  localparam int BW = $clog2(OUT_BYTES + 1);
  localparam int IW = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
  localparam int PAD_W = OUT_TDATA_W - PACKED_W - COUNT_W;

  logic [DATA_W-1:0]   buf_r [OUT_BYTES];
  logic [BW-1:0]       buf_cnt_r;
  logic                buf_full;
  logic [PACKED_W-1:0] word;

  logic                out_valid_r;
  logic [PACKED_W-1:0] out_word_r;
  logic [COUNT_W-1:0]  out_cnt_r;
  logic                out_user_r;
  logic                out_last_r;

  logic out_busy;
  logic take_byte;
  logic do_close;

  assign buf_full  = (buf_cnt_r == BW'(OUT_BYTES));
  assign out_busy  = out_valid_r && !out_tready;
  assign take_byte = emit.vld && !(buf_full && out_busy);
  assign do_close  = emit.close && (buf_cnt_r != '0) && !out_busy;

  assign stat.emit_stall = emit.vld && buf_full && out_busy;
  assign stat.close_ok   = (buf_cnt_r == '0) || !out_busy;

  // Build the beat word, bytes beyond the fill count read as zero
  always_comb begin
    word = '0;
    for (int j = 0; j < OUT_BYTES; j++) begin
      if (BW'(j) < buf_cnt_r) begin
        word[8*j +: 8] = buf_r[j];
      end
    end
  end

  // Fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_byte) begin
        buf_cnt_r <= buf_full ? BW'(1) : buf_cnt_r + BW'(1);
      end else if (do_close) begin
        buf_cnt_r <= '0;
      end
      if ((take_byte && buf_full) || do_close) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Byte lanes and beat payload
  always_ff @(posedge clk) begin
    if (take_byte) begin
      if (buf_full) begin
        buf_r[0]   <= emit.value;
        out_word_r <= word;
        out_cnt_r  <= COUNT_W'(OUT_BYTES);
        out_user_r <= 1'b0;
        out_last_r <= 1'b0;
      end else begin
        buf_r[buf_cnt_r[IW-1:0]] <= emit.value;
      end
    end else if (do_close) begin
      out_word_r <= word;
      out_cnt_r  <= COUNT_W'(buf_cnt_r);
      out_user_r <= 1'b1;
      out_last_r <= emit.eos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_cnt_r, out_word_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/rlebc_seq.sv -----
// Compression sequencer: holds run and literal state, decides the blocks of each source
// byte and walks them out one byte a cycle through the literal store unless the packer stalls.
// Depends on rlebc_pkg; drives the literal store RAM and the packer.
module rlebc_seq #(
  parameter int MAX_BLOCK = rlebc_pkg::DEF_MAX_BLOCK,
  localparam int AW = $clog2(MAX_BLOCK)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rlebc_pkg::cfg_t                  cfg,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlebc_pkg::DATA_W-1:0]     in_data,
  input  logic                             in_final,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [rlebc_pkg::DATA_W-1:0]     mem_wdata,
  output logic [AW-1:0]                    mem_raddr,
  input  logic [rlebc_pkg::DATA_W-1:0]     mem_rdata,
  output rlebc_pkg::emit_t                 emit,
  input  rlebc_pkg::pk_stat_t              pk_stat
);

  import rlebc_pkg::*;

  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MAIN  = 10'b00_0000_0010,
    S_HDR   = 10'b00_0000_0100,
    S_ADD   = 10'b00_0000_1000,
    S_FLCNT = 10'b00_0001_0000,
    S_FLDAT = 10'b00_0010_0000,
    S_REPC  = 10'b00_0100_0000,
    S_REPV  = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Current item
  logic [DATA_W-1:0] b_r, b_nxt;
  logic              fin_r, fin_nxt;
  logic              fin_todo_r, fin_todo_nxt;

  // Stream state
  logic [CW-1:0]     lit_cnt_r, lit_cnt_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [CW-1:0]     run_len_r, run_len_nxt;
  logic              run_cont_r, run_cont_nxt;
  logic              hdr_sent_r, hdr_sent_nxt;

  // Queued block work for the current item
  logic              hdr_pend_r, hdr_pend_nxt;
  logic [1:0]        hdr_idx_r, hdr_idx_nxt;
  logic              add_pend_r, add_pend_nxt;
  logic [DATA_W-1:0] add_val_r, add_val_nxt;
  logic              fl_pend_r, fl_pend_nxt;
  logic              rep_pend_r, rep_pend_nxt;
  logic [CW-1:0]     rep_cnt_r, rep_cnt_nxt;
  logic [DATA_W-1:0] rep_val_r, rep_val_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  logic          in_fire;
  logic          stall;
  logic          disp;
  logic          eq;
  logic [CW-1:0] run_inc;

  // Pending copies form a repeat block
  function automatic logic rep_due(input logic [CW-1:0] rl, input logic rc);
    return (rl >= CW'(2)) || (rc && (rl != '0));
  endfunction

  // Pick the next piece of work in block order
  function automatic state_t pick(input logic hdr, input logic add, input logic fl,
                                 input logic cnt_nz, input logic rep,
                                 input logic fin_todo);
    state_t s;
    priority if (hdr)           s = S_HDR;
    else if (add)               s = S_ADD;
    else if (fl && cnt_nz)      s = S_FLCNT;
    else if (rep)               s = S_REPC;
    else if (fin_todo)          s = S_FIN;
    else                        s = S_DONE;
    return s;
  endfunction

  assign in_tready = (state_r == S_IDLE) || ((state_r == S_DONE) && pk_stat.close_ok);
  assign in_fire   = in_tvalid && in_tready;
  assign stall     = pk_stat.emit_stall;
  assign eq        = have_prev_r && (b_r == prev_r);
  assign run_inc   = run_len_r + CW'(1);

  // Next-state and block decisions
  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    fin_nxt       = fin_r;
    fin_todo_nxt  = fin_todo_r;
    lit_cnt_nxt   = lit_cnt_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    run_len_nxt   = run_len_r;
    run_cont_nxt  = run_cont_r;
    hdr_sent_nxt  = hdr_sent_r;
    hdr_pend_nxt  = hdr_pend_r;
    hdr_idx_nxt   = hdr_idx_r;
    add_pend_nxt  = add_pend_r;
    add_val_nxt   = add_val_r;
    fl_pend_nxt   = fl_pend_r;
    rep_pend_nxt  = rep_pend_r;
    rep_cnt_nxt   = rep_cnt_r;
    rep_val_nxt   = rep_val_r;
    idx_nxt       = idx_r;
    disp          = 1'b0;
    emit          = '0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(lit_cnt_r);
    mem_wdata     = add_val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          b_nxt        = in_data;
          fin_nxt      = in_final;
          fin_todo_nxt = in_final;
          state_nxt    = S_MAIN;
        end
      end

      // Decide the blocks caused by the new byte and update the run
      S_MAIN: begin
        hdr_pend_nxt = !hdr_sent_r && cfg.embed_length;
        hdr_sent_nxt = 1'b1;
        hdr_idx_nxt  = '0;
        if (eq) begin
          fl_pend_nxt = (run_inc == CW'(2));
          if (run_inc >= CW'(MAX_BLOCK)) begin
            rep_pend_nxt = 1'b1;
            rep_cnt_nxt  = run_inc;
            rep_val_nxt  = prev_r;
            run_len_nxt  = '0;
            run_cont_nxt = 1'b1;
          end else begin
            run_len_nxt = run_inc;
          end
        end else begin
          if (have_prev_r) begin
            priority if (rep_due(run_len_r, run_cont_r)) begin
              fl_pend_nxt  = 1'b1;
              rep_pend_nxt = 1'b1;
              rep_cnt_nxt  = run_len_r;
              rep_val_nxt  = prev_r;
            end else if (run_len_r == CW'(1)) begin
              add_pend_nxt = 1'b1;
              add_val_nxt  = prev_r;
            end else begin
              // nothing pending right after a split run
            end
          end
          prev_nxt      = b_r;
          have_prev_nxt = 1'b1;
          run_len_nxt   = CW'(1);
          run_cont_nxt  = 1'b0;
        end
        disp = 1'b1;
      end

      // Length header, low byte first
      S_HDR: begin
        emit.vld   = 1'b1;
        emit.value = cfg.original_length[8*hdr_idx_r +: 8];
        if (!stall) begin
          hdr_idx_nxt = hdr_idx_r + 2'(1);
          if (hdr_idx_r == 2'(HDR_BYTES - 1)) begin
            hdr_pend_nxt = 1'b0;
            disp         = 1'b1;
          end
        end
      end

      // Store one literal; a full block is flushed next
      S_ADD: begin
        mem_we       = 1'b1;
        lit_cnt_nxt  = lit_cnt_r + CW'(1);
        fl_pend_nxt  = fl_pend_r || (lit_cnt_nxt >= CW'(MAX_BLOCK));
        add_pend_nxt = 1'b0;
        disp         = 1'b1;
      end

      // Literal block count byte; start reading the store
      S_FLCNT: begin
        emit.vld   = 1'b1;
        emit.value = DATA_W'(lit_cnt_r);
        idx_nxt    = '0;
        if (!stall) begin
          state_nxt = S_FLDAT;
        end
      end

      // Literal bytes; hold the read address while the packer stalls
      S_FLDAT: begin
        emit.vld   = 1'b1;
        emit.value = mem_rdata;
        if (!stall) begin
          if (CW'(idx_r) + CW'(1) == lit_cnt_r) begin
            lit_cnt_nxt = '0;
            disp        = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_REPC: begin
        emit.vld   = 1'b1;
        emit.value = REPEAT_FLAG | DATA_W'(rep_cnt_r);
        if (!stall) begin
          state_nxt = S_REPV;
        end
      end

      S_REPV: begin
        emit.vld   = 1'b1;
        emit.value = rep_val_r;
        if (!stall) begin
          rep_pend_nxt = 1'b0;
          disp         = 1'b1;
        end
      end

      // End of stream: close the pending run, flush literals, clear stream state
      S_FIN: begin
        fin_todo_nxt = 1'b0;
        priority if (rep_due(run_len_r, run_cont_r)) begin
          rep_pend_nxt = 1'b1;
          rep_cnt_nxt  = run_len_r;
          rep_val_nxt  = prev_r;
        end else if (run_len_r == CW'(1)) begin
          add_pend_nxt = 1'b1;
          add_val_nxt  = prev_r;
        end else begin
          // nothing pending right after a split run
        end
        fl_pend_nxt   = 1'b1;
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
        run_len_nxt   = '0;
        run_cont_nxt  = 1'b0;
        hdr_sent_nxt  = 1'b0;
        disp          = 1'b1;
      end

      // Close the item's last beat; take the next byte in the same cycle
      S_DONE: begin
        emit.close = 1'b1;
        emit.eos   = fin_r;
        if (pk_stat.close_ok) begin
          if (in_fire) begin
            b_nxt        = in_data;
            fin_nxt      = in_final;
            fin_todo_nxt = in_final;
            state_nxt    = S_MAIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Move on to the next queued block; a flush request survives only ahead of it
    if (disp) begin
      state_nxt = pick(hdr_pend_nxt, add_pend_nxt, fl_pend_nxt, lit_cnt_nxt != '0,
                       rep_pend_nxt, fin_todo_nxt);
      if ((state_nxt != S_HDR) && (state_nxt != S_ADD)) begin
        fl_pend_nxt = 1'b0;
      end
    end

    mem_raddr = idx_nxt;
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_todo_r  <= 1'b0;
      lit_cnt_r   <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      run_len_r   <= '0;
      run_cont_r  <= 1'b0;
      hdr_sent_r  <= 1'b0;
      hdr_pend_r  <= 1'b0;
      add_pend_r  <= 1'b0;
      fl_pend_r   <= 1'b0;
      rep_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_todo_r  <= fin_todo_nxt;
      lit_cnt_r   <= lit_cnt_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      run_len_r   <= run_len_nxt;
      run_cont_r  <= run_cont_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      hdr_pend_r  <= hdr_pend_nxt;
      add_pend_r  <= add_pend_nxt;
      fl_pend_r   <= fl_pend_nxt;
      rep_pend_r  <= rep_pend_nxt;
    end
  end

  // Item and block payload
  always_ff @(posedge clk) begin
    b_r       <= b_nxt;
    fin_r     <= fin_nxt;
    hdr_idx_r <= hdr_idx_nxt;
    add_val_r <= add_val_nxt;
    rep_cnt_r <= rep_cnt_nxt;
    rep_val_r <= rep_val_nxt;
    idx_r     <= idx_nxt;
  end

endmodule

// ----- rtl/rle_byte_compressor_unit.sv -----
// Byte run-length compressor, top level: config registers, sequencer, literal store, packer.
// Flow: an accepted byte is registered, the main state decides its blocks, then the sequencer
// works through those that apply: the four header bytes, a literal store, the literal count and
// stored bytes, and a repeat count and value, each byte held while the packer stalls; a final byte
// adds the stream-end step, and each item ends with a close step that can take the next byte.
// Reset (rst_n, synchronous): clears control, stream state and registers; store is not cleared.
module rle_byte_compressor_unit #(
  parameter int MAX_BLOCK = rlebc_pkg::DEF_MAX_BLOCK,
  parameter int OUT_BYTES = rlebc_pkg::DEF_OUT_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rlebc_pkg::DATA_W-1:0]        in_tdata,   // data_byte
  input  logic                                in_tlast,   // final_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rlebc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // packed_bytes, byte_count
  output logic                                out_tuser,  // last_of_input
  output logic                                out_tlast,  // end_of_stream
  input  logic                                cfg_wr_en,
  input  logic [rlebc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [rlebc_pkg::LEN_W-1:0]         cfg_wdata
);

  import rlebc_pkg::*;

  localparam int AW = $clog2(MAX_BLOCK);

  cfg_t     cfg_r;
  emit_t    emit;
  pk_stat_t pk_stat;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EMBED_LENGTH:    cfg_r.embed_length    <= cfg_wdata[0];
        REG_ORIGINAL_LENGTH: cfg_r.original_length <= cfg_wdata;
      endcase
    end
  end

  rlebc_seq #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_final  (in_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .emit      (emit),
    .pk_stat   (pk_stat)
  );

  rlebc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BLOCK)
  ) u_lit_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rlebc_packer #(
    .OUT_BYTES (OUT_BYTES)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .stat       (pk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A stream's final beat is always the last beat of its item
  a_eos_is_item_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of stream on a beat that does not close its item");

  // Every beat carries between one and OUT_BYTES bytes
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PACKED_W +: COUNT_W] != '0) &&
                   (out_tdata[PACKED_W +: COUNT_W] <= COUNT_W'(OUT_BYTES)))
    else $error("beat byte count out of range");

  // A stalled byte, store read data included, holds until the packer takes it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld && pk_stat.emit_stall |=> emit.vld && $stable(emit.value))
    else $error("compressed byte changed while stalled");

  // The literal store is never written while a new source byte can be taken
  a_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_tready)
    else $error("literal store written while accepting input");

endmodule
